@@ rtl/sgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sgs_pkg
// Types and codes shared by the scrolling grid store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_SHIFT = 2'd2;

  localparam logic REG_FILL = 1'b0;

  // signed width for source coordinates: up to 8-bit col minus 8-bit offset
  localparam int SRC_W = 10;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [3:0]        cell_value;
    logic signed [7:0] shift_x;
    logic signed [7:0] shift_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0] read_data;
    logic       range_error;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic use_fill;
    logic done;
  } scan_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sgs_ram.sv @@
// ----------------------------------------------------------------------------
// sgs_ram
// Simple dual-port cell memory: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/sgs_scan.sv @@
// ----------------------------------------------------------------------------
// sgs_scan
// Shift sequencer: walks every destination cell once, issues the source
// read in the cycle before the destination write.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_scan
  import sgs_pkg::*;
#(
  parameter int GRID_DIM = 64,
  parameter int CW       = 6,
  parameter int AW       = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic signed [7:0] dx,
  input  wire logic signed [7:0] dy,
  output scan_ctl_t              ctl,
  output logic        [AW-1:0]   rd_addr,
  output logic        [AW-1:0]   wr_addr
);

  logic              active_r;
  logic [CW-1:0]     c_r, r_r;
  logic [AW-1:0]     d_idx_r;
  logic signed [7:0] dx_r, dy_r;
  logic              s1_valid_r, s1_fill_r, s1_last_r;
  logic [AW-1:0]     s1_addr_r;

  logic signed [SRC_W-1:0] sc, sr;
  logic                    in_src, row_end, last;

  always_comb begin
    sc      = $signed(SRC_W'(c_r)) - SRC_W'(dx_r);
    sr      = $signed(SRC_W'(r_r)) - SRC_W'(dy_r);
    in_src  = (sc >= 0) && (sc < $signed(SRC_W'(GRID_DIM))) &&
              (sr >= 0) && (sr < $signed(SRC_W'(GRID_DIM)));
    row_end = (r_r == CW'(GRID_DIM - 1));
    last    = row_end && (c_r == CW'(GRID_DIM - 1));
    rd_addr = AW'(AW'(sc[CW-1:0]) * AW'(GRID_DIM) + AW'(sr[CW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= active_r;
      if (start) begin
        active_r <= 1'b1;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      c_r     <= '0;
      r_r     <= '0;
      d_idx_r <= '0;
      dx_r    <= dx;
      dy_r    <= dy;
    end else if (active_r) begin
      d_idx_r <= d_idx_r + AW'(1);
      if (row_end) begin
        r_r <= '0;
        c_r <= c_r + CW'(1);
      end else begin
        r_r <= r_r + CW'(1);
      end
    end
    s1_addr_r <= d_idx_r;
    s1_fill_r <= !in_src;
    s1_last_r <= last;
  end

  always_comb begin
    ctl.rd_en    = active_r && in_src;
    ctl.wr_en    = s1_valid_r;
    ctl.use_fill = s1_fill_r;
    ctl.done     = s1_valid_r && s1_last_r;
    wr_addr      = s1_addr_r;
  end

endmodule

`default_nettype wire

@@ rtl/scrolling_grid_store.sv @@
// ----------------------------------------------------------------------------
// scrolling_grid_store
// Square grid of cell codes with read, write and whole-grid shift, held in
// two cell banks that swap roles on each shift.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall    in_item_t  (kind, col, row, ...)
//  out_     output     out_valid / out_stall  out_item_t (read_data, error)
//  cfg_     input      APB psel/penable       fill_value at byte address 0
//
//  Read and write: one item per cycle while in_stall is low; a read result
//  appears the next cycle. Shift: one cell per cycle through the bank read
//  port; its result appears when the last cell is written.
//  After reset bank 0 is cleared one cell per cycle, with in_stall high.
//  in_stall is also high during a shift and while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_grid_store
  import sgs_pkg::*;
#(
  parameter int GRID_DIM  = 64,
  parameter int CELL_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);

  state_t state_r, state_nxt;
  logic   bank_r;
  logic   [AW-1:0] clr_addr_r;
  logic   [3:0]    fill_r;
  logic   out_valid_r, out_read_r, out_err_r;

  logic   in_acc, in_bounds, host_we, host_re, clearing, shifting, shift_go;
  logic   [AW-1:0] host_addr;

  scan_ctl_t     scan_ctl;
  logic [AW-1:0] scan_raddr, scan_waddr;

  logic                 we0, we1, re0, re1;
  logic [AW-1:0]        waddr0, waddr1, raddr;
  logic [CELL_BITS-1:0] wdata, rd0, rd1, rd_act, fill_cell;

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_FILL) begin
      fill_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FILL) ? {28'd0, fill_r} : 32'd0;

  // control
  always_comb begin
    state_nxt = state_r;
    clearing  = 1'b0;
    shifting  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (shift_go) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        shifting = 1'b1;
        if (scan_ctl.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      bank_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (scan_ctl.done) begin
        bank_r <= !bank_r;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign in_bounds = ({1'b0, in_data.col} < 9'(GRID_DIM)) &&
                     ({1'b0, in_data.row} < 9'(GRID_DIM));
  assign host_addr = AW'(AW'(in_data.col) * AW'(GRID_DIM) + AW'(in_data.row));
  assign host_we   = in_acc && in_data.kind == KIND_WRITE && in_bounds;
  assign host_re   = in_acc && in_data.kind == KIND_READ && in_bounds;
  assign shift_go  = in_acc && in_data.kind == KIND_SHIFT;

  sgs_scan #(
    .GRID_DIM (GRID_DIM),
    .CW       (CW),
    .AW       (AW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (shift_go),
    .dx      (in_data.shift_x),
    .dy      (in_data.shift_y),
    .ctl     (scan_ctl),
    .rd_addr (scan_raddr),
    .wr_addr (scan_waddr)
  );

  // bank steering: host and shift source use the active bank,
  // shift destination is the other one
  assign rd_act    = bank_r ? rd1 : rd0;
  assign fill_cell = CELL_BITS'(fill_r);

  always_comb begin
    we0    = clearing || (host_we && !bank_r) || (scan_ctl.wr_en && bank_r);
    we1    = (host_we && bank_r) || (scan_ctl.wr_en && !bank_r);
    re0    = (host_re || (shifting && scan_ctl.rd_en)) && !bank_r;
    re1    = (host_re || (shifting && scan_ctl.rd_en)) && bank_r;
    waddr0 = clearing ? clr_addr_r : (scan_ctl.wr_en ? scan_waddr : host_addr);
    waddr1 = scan_ctl.wr_en ? scan_waddr : host_addr;
    raddr  = shifting ? scan_raddr : host_addr;
    if (clearing) begin
      wdata = '0;
    end else if (scan_ctl.wr_en) begin
      wdata = scan_ctl.use_fill ? fill_cell : rd_act;
    end else begin
      wdata = CELL_BITS'(in_data.cell_value);
    end
  end

  sgs_ram #(.DEPTH(CELLS), .AW(AW), .DW(CELL_BITS)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata),
    .re    (re0),
    .raddr (raddr),
    .rdata (rd0)
  );

  sgs_ram #(.DEPTH(CELLS), .AW(AW), .DW(CELL_BITS)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata),
    .re    (re1),
    .raddr (raddr),
    .rdata (rd1)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_ctl.done || (in_acc && in_data.kind != KIND_SHIFT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ctl.done) begin
      out_read_r <= 1'b0;
      out_err_r  <= 1'b0;
    end else if (in_acc) begin
      out_read_r <= host_re;
      out_err_r  <= !in_bounds &&
                    (in_data.kind == KIND_READ || in_data.kind == KIND_WRITE);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.read_data = out_read_r ? 4'(rd_act) : 4'd0;
  assign out_data.range_error = out_err_r;

  // checks
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("item accepted while clearing or shifting");

  a_shift_src_kept: assert property (@(posedge clk) disable iff (!rst_n)
    scan_ctl.wr_en |-> !(bank_r ? we1 : we0))
    else $error("shift wrote the source bank");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == KIND_READ) |=> out_valid_r)
    else $error("read gave no result");

  a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
    scan_ctl.done |=> (state_r == ST_IDLE && out_valid_r && bank_r != $past(bank_r)))
    else $error("shift end did not swap banks and report");

endmodule

`default_nettype wire
